// ===== design/dbbrf_pkg.sv =====
package dbbrf_pkg;

    localparam int CHANNELS  = 2;
    localparam int CH_W      = 1;
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 24;
    localparam int ACC_W     = 32;
    localparam int COEF_FRAC = 20;

    // product and accumulator widths
    localparam int PX_W  = SAMPLE_W + COEF_W;
    localparam int PY_W  = ACC_W + COEF_W;
    localparam int SUM_W = PY_W + 3;
    localparam int RND_W = SUM_W - COEF_FRAC;

    // output queue
    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = 3;
    localparam int OCC_W     = PTR_W + 1;

    // APB
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [IDX_W-1:0] REG_HP_A1  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HP_B1  = 3'd2;
    localparam logic [IDX_W-1:0] REG_HP_B2  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LP_A1  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LP_B1  = 3'd5;
    localparam logic [IDX_W-1:0] REG_LP_B2  = 3'd6;

    // per-channel delay line, one memory word
    typedef struct packed {
        logic [SAMPLE_W-1:0] x1;
        logic [SAMPLE_W-1:0] x2;
        logic [ACC_W-1:0]    hy1;
        logic [ACC_W-1:0]    hy2;
        logic [ACC_W-1:0]    ly1;
        logic [ACC_W-1:0]    ly2;
    } t_state;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
    } t_out;

    // round half up, drop the fraction, saturate to ACC_W
    function automatic logic [ACC_W-1:0] sect_round(input logic signed [SUM_W-1:0] acc);
        logic signed [SUM_W-1:0] r;
        logic [RND_W-1:0]        q;
        r = acc + (SUM_W'(1) <<< (COEF_FRAC - 1));
        q = r[SUM_W-1:COEF_FRAC];
        if ((&q[RND_W-1:ACC_W-1]) || !(|q[RND_W-1:ACC_W-1]))
            return q[ACC_W-1:0];
        else if (q[RND_W-1])
            return {1'b1, {(ACC_W-1){1'b0}}};
        else
            return {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    // saturate a sum of two section outputs to the sample width
    function automatic logic [SAMPLE_W-1:0] out_sat(input logic [ACC_W:0] s);
        if ((&s[ACC_W:SAMPLE_W-1]) || !(|s[ACC_W:SAMPLE_W-1]))
            return s[SAMPLE_W-1:0];
        else if (s[ACC_W])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

// ===== design/dual_biquad_band_reject_filter.sv =====
// Band-reject filter: a highpass and a lowpass biquad run side by side on
// each channel's delay state, their outputs add and saturate to 24 bits.
//
// Input stream: s_axis_tdata carries the Q1.23 sample, s_axis_tuser the
// channel. Output stream: m_axis_tdata carries the result sample,
// m_axis_tuser its channel. A request moves when tvalid and tready are high.
// Coefficients and enable come in over the APB port (pready tied high).
//
// Throughput: one sample per cycle while the queue has room. The other wait
// is a sample for the same channel as the sample accepted in the cycle
// before: it is held back, as the feedback products need that sample's
// section outputs, which come out of the accumulate stage and are written
// back to the state memory.
//
// The result queue holds 8 entries and counts everything in flight, so
// samples keep flowing while the receiver stalls until 8 are accepted and
// not yet delivered; then s_axis_tready drops. Nothing is lost or reordered.
//
// Reset clears the configuration, stage valid bits, queue pointers and the
// per-channel valid bits; a channel never written reads its history as zero.
module dual_biquad_band_reject_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dbbrf_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dbbrf_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [23:0] sample_in
    input  logic [dbbrf_pkg::CH_W-1:0]        s_axis_tuser,  // [0] channel
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dbbrf_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // [23:0] sample_out
    output logic [dbbrf_pkg::CH_W-1:0]        m_axis_tuser   // [0] channel_out
);

    localparam int SW    = dbbrf_pkg::SAMPLE_W;
    localparam int CW    = dbbrf_pkg::COEF_W;
    localparam int AW    = dbbrf_pkg::ACC_W;
    localparam int NCH   = dbbrf_pkg::CHANNELS;
    localparam int CHW   = dbbrf_pkg::CH_W;
    localparam int PXW   = dbbrf_pkg::PX_W;
    localparam int PYW   = dbbrf_pkg::PY_W;
    localparam int SMW   = dbbrf_pkg::SUM_W;
    localparam int PW    = dbbrf_pkg::PTR_W;
    localparam int OW    = dbbrf_pkg::OCC_W;
    localparam int DEPTH = dbbrf_pkg::OUT_DEPTH;
    localparam int IW    = dbbrf_pkg::IDX_W;

    // ---------------- configuration ----------------
    logic                 r_enable;
    logic signed [CW-1:0] r_hp_a1, r_hp_b1, r_hp_b2;
    logic signed [CW-1:0] r_lp_a1, r_lp_b1, r_lp_b2;
    logic [IW-1:0]        reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dbbrf_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_hp_a1  <= '0;
            r_hp_b1  <= '0;
            r_hp_b2  <= '0;
            r_lp_a1  <= '0;
            r_lp_b1  <= '0;
            r_lp_b2  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                dbbrf_pkg::REG_ENABLE: r_enable <= pwdata[0];
                dbbrf_pkg::REG_HP_A1:  r_hp_a1  <= pwdata[CW-1:0];
                dbbrf_pkg::REG_HP_B1:  r_hp_b1  <= pwdata[CW-1:0];
                dbbrf_pkg::REG_HP_B2:  r_hp_b2  <= pwdata[CW-1:0];
                dbbrf_pkg::REG_LP_A1:  r_lp_a1  <= pwdata[CW-1:0];
                dbbrf_pkg::REG_LP_B1:  r_lp_b1  <= pwdata[CW-1:0];
                dbbrf_pkg::REG_LP_B2:  r_lp_b2  <= pwdata[CW-1:0];
                default: ;  // unmapped, dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dbbrf_pkg::REG_ENABLE: prdata = {31'd0, r_enable};
            dbbrf_pkg::REG_HP_A1:  prdata = {{(32-CW){1'b0}}, r_hp_a1};
            dbbrf_pkg::REG_HP_B1:  prdata = {{(32-CW){1'b0}}, r_hp_b1};
            dbbrf_pkg::REG_HP_B2:  prdata = {{(32-CW){1'b0}}, r_hp_b2};
            dbbrf_pkg::REG_LP_A1:  prdata = {{(32-CW){1'b0}}, r_lp_a1};
            dbbrf_pkg::REG_LP_B1:  prdata = {{(32-CW){1'b0}}, r_lp_b1};
            dbbrf_pkg::REG_LP_B2:  prdata = {{(32-CW){1'b0}}, r_lp_b2};
            default:               prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // stage 1: memory read data valid, products formed
    // stage 2: sums, round/saturate, state write-back
    // stage 3: final sum, push into result queue
    logic           r_v1, r_v2, r_v3;
    logic [CHW-1:0] r_ch1, r_ch2, r_ch3;
    logic [OW-1:0]  r_occ;     // accepted but not yet delivered
    logic [OW-1:0]  r_wp, r_rp;
    logic           in_fire, out_fire, hazard, st_we;

    // same channel right behind: its history is still being computed
    assign hazard        = r_v1 && (r_ch1 == s_axis_tuser);
    assign s_axis_tready = (r_occ < OW'(DEPTH)) && !hazard;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_wp != r_rp);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign st_we         = r_v2 && r_enable;

    // ---------------- state memory ----------------
    dbbrf_pkg::t_state mem [NCH];
    dbbrf_pkg::t_state r_rd;
    dbbrf_pkg::t_state n_wst;
    logic [NCH-1:0]    r_ok;      // entry written since reset
    logic              r_rd_ok;
    logic              bypass;

    // write and read of the same entry in one cycle: take the new word
    assign bypass = st_we && (r_ch2 == s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (st_we)
            mem[r_ch2] <= n_wst;
        if (in_fire)
            r_rd <= bypass ? n_wst : mem[s_axis_tuser];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok    <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (st_we)
                r_ok[r_ch2] <= 1'b1;
            if (in_fire)
                r_rd_ok <= bypass || r_ok[s_axis_tuser];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_occ <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            r_v1  <= in_fire;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_occ <= r_occ + OW'(in_fire) - OW'(out_fire);
            if (r_v3)
                r_wp <= r_wp + OW'(1);
            if (out_fire)
                r_rp <= r_rp + OW'(1);
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [SW-1:0] r_x0_1;
    dbbrf_pkg::t_state    st1;

    assign st1 = r_rd_ok ? r_rd : '0;

    logic signed [PXW-1:0] r_ph0, r_ph1, r_ph2, r_pl0, r_pl1, r_pl2;
    logic signed [PYW-1:0] r_ph3, r_ph4, r_pl3, r_pl4;
    logic signed [SW-1:0]  r_x0_2;
    dbbrf_pkg::t_state     r_st2;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ch1  <= s_axis_tuser;
            r_x0_1 <= s_axis_tdata;
        end
        // middle taps are -2*a1 / +2*a1: the doubling happens in the sum
        r_ph0  <= r_hp_a1 * r_x0_1;
        r_ph1  <= r_hp_a1 * $signed(st1.x1);
        r_ph2  <= r_hp_a1 * $signed(st1.x2);
        r_ph3  <= r_hp_b1 * $signed(st1.hy1);
        r_ph4  <= r_hp_b2 * $signed(st1.hy2);
        r_pl0  <= r_lp_a1 * r_x0_1;
        r_pl1  <= r_lp_a1 * $signed(st1.x1);
        r_pl2  <= r_lp_a1 * $signed(st1.x2);
        r_pl3  <= r_lp_b1 * $signed(st1.ly1);
        r_pl4  <= r_lp_b2 * $signed(st1.ly2);
        r_ch2  <= r_ch1;
        r_x0_2 <= r_x0_1;
        r_st2  <= st1;
    end

    // ---------------- stage 2: section sums ----------------
    logic signed [SMW-1:0] acc_hp, acc_lp;
    logic [AW-1:0]         hp, lp;

    assign acc_hp = SMW'(r_ph0) - (SMW'(r_ph1) <<< 1) + SMW'(r_ph2)
                  - SMW'(r_ph3) - SMW'(r_ph4);
    assign acc_lp = SMW'(r_pl0) + (SMW'(r_pl1) <<< 1) + SMW'(r_pl2)
                  - SMW'(r_pl3) - SMW'(r_pl4);
    assign hp     = dbbrf_pkg::sect_round(acc_hp);
    assign lp     = dbbrf_pkg::sect_round(acc_lp);

    always_comb begin
        n_wst.x1  = r_x0_2;
        n_wst.x2  = r_st2.x1;
        n_wst.hy1 = hp;
        n_wst.hy2 = r_st2.hy1;
        n_wst.ly1 = lp;
        n_wst.ly2 = r_st2.ly1;
    end

    logic [AW-1:0]        r_hp3, r_lp3;
    logic signed [SW-1:0] r_x0_3;

    always_ff @(posedge i_clk) begin
        r_hp3  <= hp;
        r_lp3  <= lp;
        r_ch3  <= r_ch2;
        r_x0_3 <= r_x0_2;
    end

    // ---------------- stage 3: final sum, result queue ----------------
    logic [AW:0]         sum3;
    dbbrf_pkg::t_out     res3;
    dbbrf_pkg::t_out     r_q [DEPTH];

    assign sum3        = {r_hp3[AW-1], r_hp3} + {r_lp3[AW-1], r_lp3};
    assign res3.ch     = r_ch3;
    assign res3.sample = r_enable ? dbbrf_pkg::out_sat(sum3) : r_x0_3;

    always_ff @(posedge i_clk) begin
        if (r_v3)
            r_q[r_wp[PW-1:0]] <= res3;
    end

    assign m_axis_tdata = r_q[r_rp[PW-1:0]].sample;
    assign m_axis_tuser = r_q[r_rp[PW-1:0]].ch;

endmodule
